FILE: rtl/pbq_pkg.sv
// ============================================================================
// pbq_pkg : shared types, constants and helpers of the bilevel quantizer
// Holds the mode codes, register indexes, the 8x8 ordered-dither matrix,
// the pipeline item record and the error-line control record.
// ============================================================================
package pbq_pkg;

   // default size limits of the frame
   localparam int DEFAULT_MAX_WIDTH  = 1024;
   localparam int DEFAULT_MAX_HEIGHT = 1024;

   // at most this many groups of the error line get a valid flag
   localparam int VALID_GROUPS_MAX = 256;

   // configuration register indexes
   localparam logic [1:0] CSR_MODE         = 2'd0;
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd2;

   // reset value of the size registers
   localparam logic [10:0] SIZE_RESET = 11'd1024;

   // quantizer modes
   typedef enum logic [1:0] {
      MODE_THRESHOLD = 2'd0,
      MODE_BAYER     = 2'd1,
      MODE_DIFFUSE   = 2'd2,
      MODE_PASS      = 2'd3
   } pbq_mode_type;

   // one pixel on its way from the counters to the quantizer
   typedef struct packed {
      logic [7:0] pixel;
      logic       frame_start;
      logic       last_col;
      logic       last_row;
      logic       col_zero;
      logic [2:0] bayer_row;
      logic [2:0] bayer_col;
   } pbq_item_type;

   // error line store control
   typedef struct packed {
      logic wr_en;
      logic clear;
   } pbq_ls_ctl_type;

   // 8x8 ordered-dither matrix, row-major
   localparam logic [5:0] BAYER_TABLE [64] = '{
      6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42,
      6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
      6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38,
      6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
      6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41,
      6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
      6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37,
      6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
   };

   function automatic logic [5:0] bayer_level(input logic [2:0] row, input logic [2:0] col);
      return BAYER_TABLE[{row, col}];
   endfunction

   // err * k / 16, truncated toward zero
   function automatic logic signed [7:0] scale_err(input logic signed [8:0] err,
                                                   input logic [3:0] k);
      logic signed [13:0] prod;
      prod = 14'(err) * $signed({10'd0, k});
      if (prod < 0) begin
         prod = prod + 14'sd15;
      end
      return 8'(prod >>> 4);
   endfunction

endpackage

FILE: rtl/pixel_bilevel_quantizer_core.sv
// ============================================================================
// pixel_bilevel_quantizer_core : bilevel quantizer of a grey pixel stream
// Grey pixels come in raster order on the req_ stream, one output pixel per
// item leaves on the rsp_ stream. Modes: threshold, 8x8 ordered dither,
// error diffusion with a next-row error line in a synchronous memory, and pass.
//
// Usage:
//  - req_tdata carries the pixel, req_tuser marks the first pixel of a frame.
//  - rsp_tdata carries the quantized pixel, rsp_tlast marks the last pixel of
//    a row, rsp_tuser the last pixel of the frame.
//  - csr_we/csr_addr/csr_wdata set mode, width and height; write them only
//    while no item is in flight.
//  - One item per cycle sustained while rsp_tready is held. An item waits in
//    the work stage for its error line read, then moves to the output
//    register. The error carry to the next pixel goes through a right-carry register.
//  - Reset: counters at row 0, column 0, mode threshold, 1024 x 1024, error
//    line reads as zero at once through its group valid flags.
//  - When the receiver stalls, the output register holds its item and the
//    work stage takes one more; then req_tready drops until rsp_tready.
// ============================================================================
module pixel_bilevel_quantizer_core #(
   parameter int MAX_WIDTH  = pbq_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = pbq_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel_in
   input  logic        req_tuser,   // [0] frame_start
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] pixel_out
   output logic        rsp_tlast,   // row_end
   output logic        rsp_tuser,   // [0] frame_end
   // configuration writes
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [10:0] csr_wdata
);
   import pbq_pkg::*;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int COLS_W = COL_W + 1;
   localparam int ROWS_W = ROW_W + 1;

   pbq_mode_type       mode_ff;
   logic [10:0]        width_ff;
   logic [10:0]        height_ff;

   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_cur;
   logic [ROW_W-1:0]   row_cur;
   logic [COLS_W-1:0]  w_lim;
   logic [ROWS_W-1:0]  h_lim;
   logic               last_col, last_row;
   logic               accept;

   logic               s1_valid_ff, s1_valid_in;
   pbq_item_type       s1_item_ff;
   logic [COL_W-1:0]   s1_col_ff;
   logic               s1_fire;

   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_pixel_ff;
   logic               out_row_end_ff;
   logic               out_frame_end_ff;

   logic [7:0]         pixel_q;
   logic signed [8:0]  line_data;
   pbq_ls_ctl_type     ls_ctl;
   logic [COL_W-1:0]   ls_addr;
   logic signed [8:0]  ls_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_THRESHOLD;
         width_ff  <= SIZE_RESET;
         height_ff <= SIZE_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_MODE:         mode_ff   <= pbq_mode_type'(csr_wdata[1:0]);
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default:          ;
         endcase
      end
   end

   // frame size limited to 1..max
   always_comb begin
      if (width_ff == 11'd0) begin
         w_lim = COLS_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_lim = COLS_W'(MAX_WIDTH);
      end else begin
         w_lim = COLS_W'(width_ff);
      end
      if (height_ff == 11'd0) begin
         h_lim = ROWS_W'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_lim = ROWS_W'(MAX_HEIGHT);
      end else begin
         h_lim = ROWS_W'(height_ff);
      end
   end

   // handshake
   assign s1_fire    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign accept     = req_tvalid && req_tready;

   // raster position of the arriving pixel
   always_comb begin
      col_cur  = req_tuser ? '0 : col_ff;
      row_cur  = req_tuser ? '0 : row_ff;
      last_col = (COLS_W'(col_cur) + COLS_W'(1)) >= w_lim;
      last_row = (ROWS_W'(row_cur) + ROWS_W'(1)) >= h_lim;
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_cur + ROW_W'(1);
         end else begin
            col_in = col_cur + COL_W'(1);
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // work stage: item waits here for its error line entry
   assign s1_valid_in = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff.pixel       <= req_tdata;
         s1_item_ff.frame_start <= req_tuser;
         s1_item_ff.last_col    <= last_col;
         s1_item_ff.last_row    <= last_row;
         s1_item_ff.col_zero    <= (col_cur == '0);
         s1_item_ff.bayer_row   <= 3'(row_cur);
         s1_item_ff.bayer_col   <= 3'(col_cur);
         s1_col_ff              <= col_cur;
      end
   end

   pbq_line_store #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .rd_data (line_data),
      .ls_ctl  (ls_ctl),
      .wr_addr (ls_addr),
      .wr_data (ls_data)
   );

   pbq_quant #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_quant (
      .clock     (clock),
      .reset     (reset),
      .fire      (s1_fire),
      .item      (s1_item_ff),
      .col       (s1_col_ff),
      .mode      (mode_ff),
      .line_data (line_data),
      .pixel_q   (pixel_q),
      .ls_ctl    (ls_ctl),
      .ls_addr   (ls_addr),
      .ls_data   (ls_data)
   );

   // output register
   assign out_valid_in = s1_fire ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         out_pixel_ff     <= pixel_q;
         out_row_end_ff   <= s1_item_ff.last_col;
         out_frame_end_ff <= s1_item_ff.last_col && s1_item_ff.last_row;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pixel_ff;
   assign rsp_tlast  = out_row_end_ff;
   assign rsp_tuser  = out_frame_end_ff;

   // a waiting work item keeps its column
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_fire |=> s1_valid_ff && $stable(s1_col_ff))
      else $error("core: work stage lost its item");

   // nothing moves into a stalled full output register
   a_out_stall: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |-> !s1_fire)
      else $error("core: output overwritten while stalled");

endmodule

FILE: rtl/pbq_line_store.sv
// ============================================================================
// pbq_line_store : next-row error line
// Synchronous memory of 9-bit signed errors, one entry per column, grouped
// into words of several lanes with a per-lane write enable. Each group has a
// valid flag; a clear drops all flags at once and an unwritten group reads as
// zero. A write in the same cycle as a read is forwarded to that read.
// ============================================================================
module pbq_line_store #(
   parameter int MAX_WIDTH = pbq_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]     rd_addr,
   output logic signed [8:0]                rd_data,
   input  pbq_pkg::pbq_ls_ctl_type          ls_ctl,
   input  logic [$clog2(MAX_WIDTH)-1:0]     wr_addr,
   input  logic signed [8:0]                wr_data
);
   import pbq_pkg::*;

   localparam int LANE_W  = (MAX_WIDTH > VALID_GROUPS_MAX) ?
                            $clog2((MAX_WIDTH + VALID_GROUPS_MAX - 1) / VALID_GROUPS_MAX) : 1;
   localparam int LANES   = 1 << LANE_W;
   localparam int GROUPS  = (MAX_WIDTH + LANES - 1) / LANES;
   localparam int GROUP_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int ADDR_W  = LANE_W + GROUP_W;

   logic [LANES-1:0][8:0] mem_array [GROUPS];

   logic [ADDR_W-1:0]    rd_addr_ext;
   logic [ADDR_W-1:0]    wr_addr_ext;
   logic [GROUP_W-1:0]   rd_group;
   logic [LANE_W-1:0]    rd_lane;
   logic [GROUP_W-1:0]   wr_group;
   logic [LANE_W-1:0]    wr_lane;
   logic                 wr_full;
   logic [LANES-1:0]     wr_we;
   logic [LANES-1:0][8:0] wr_word;

   logic [GROUPS-1:0]    valid_ff, valid_in;
   logic [LANES-1:0][8:0] rd_word_ff;
   logic [LANE_W-1:0]    rd_lane_ff;
   logic                 rd_valid_ff;
   logic                 fwd_hit_ff;
   logic [8:0]           fwd_data_ff;
   logic                 clr_hit_ff;

   // address split into group and lane
   assign rd_addr_ext = ADDR_W'(rd_addr);
   assign wr_addr_ext = ADDR_W'(wr_addr);
   assign rd_group    = rd_addr_ext[ADDR_W-1:LANE_W];
   assign rd_lane     = rd_addr_ext[LANE_W-1:0];
   assign wr_group    = wr_addr_ext[ADDR_W-1:LANE_W];
   assign wr_lane     = wr_addr_ext[LANE_W-1:0];

   // first write into a stale group zeroes its other lanes
   always_comb begin
      wr_full = ls_ctl.clear || !valid_ff[wr_group];
      for (int l = 0; l < LANES; l++) begin
         wr_we[l]   = wr_full || (LANE_W'(l) == wr_lane);
         wr_word[l] = (LANE_W'(l) == wr_lane) ? wr_data : 9'd0;
      end
   end

   // valid flags: clear first, then this cycle's write
   always_comb begin
      valid_in = valid_ff;
      if (ls_ctl.clear) begin
         valid_in = '0;
      end
      if (ls_ctl.wr_en) begin
         valid_in[wr_group] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // memory array
   always_ff @(posedge clock) begin
      if (ls_ctl.wr_en) begin
         for (int l = 0; l < LANES; l++) begin
            if (wr_we[l]) begin
               mem_array[wr_group][l] <= wr_word[l];
            end
         end
      end
      if (rd_en) begin
         rd_word_ff <= mem_array[rd_group];
      end
   end

   // read side: flag, lane and same-cycle forwarding
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
         clr_hit_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_hit_ff <= ls_ctl.wr_en && (wr_addr == rd_addr);
         clr_hit_ff <= ls_ctl.clear;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_lane_ff  <= rd_lane;
         rd_valid_ff <= valid_ff[rd_group];
         fwd_data_ff <= wr_data;
      end
   end

   always_comb begin
      if (fwd_hit_ff) begin
         rd_data = $signed(fwd_data_ff);
      end else if (clr_hit_ff || !rd_valid_ff) begin
         rd_data = 9'sd0;
      end else begin
         rd_data = $signed(rd_word_ff[rd_lane_ff]);
      end
   end

   // a bare clear leaves no group valid
   a_clear_drops_all: assert property (@(posedge clock) disable iff (reset)
      ls_ctl.clear && !ls_ctl.wr_en |=> valid_ff == '0)
      else $error("line store: group still valid after clear");

   // a written group is valid afterwards
   a_write_sets_valid: assert property (@(posedge clock) disable iff (reset)
      ls_ctl.wr_en |=> valid_ff[$past(wr_group)])
      else $error("line store: written group not valid");

endmodule

FILE: rtl/pbq_quant.sv
// ============================================================================
// pbq_quant : per-pixel quantizer and error diffusion
// Thresholding, ordered dither and error diffusion of the pixel in the
// work stage, with the right-carry and pending-below error registers and
// the write requests toward the error line store.
// ============================================================================
module pbq_quant #(
   parameter int MAX_WIDTH = pbq_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             fire,
   input  pbq_pkg::pbq_item_type            item,
   input  logic [$clog2(MAX_WIDTH)-1:0]     col,
   input  pbq_pkg::pbq_mode_type            mode,
   input  logic signed [8:0]                line_data,
   output logic [7:0]                       pixel_q,
   output pbq_pkg::pbq_ls_ctl_type          ls_ctl,
   output logic [$clog2(MAX_WIDTH)-1:0]     ls_addr,
   output logic signed [8:0]                ls_data
);
   import pbq_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic signed [7:0]  right_ff, right_in;
   logic signed [8:0]  pend0_ff, pend0_in;
   logic signed [8:0]  pend1_ff, pend1_in;
   logic               q_pend_ff, q_pend_in;
   logic [COL_W-1:0]   q_addr_ff, q_addr_in;
   logic signed [8:0]  q_data_ff, q_data_in;

   logic signed [8:0]  nre, p0, p1;
   logic signed [7:0]  rc;
   logic signed [10:0] sum;
   logic [7:0]         sat;
   logic               dq;
   logic signed [8:0]  err;
   logic               spread;
   logic signed [7:0]  t_right, t_below, t_bl, t_br;
   logic signed [9:0]  w1_sum, p0_next;
   logic               diff_fire, frame_end, line_clear;
   logic               w1_en, w2_direct, q_set, q_issue;

   // error-diffused value and its error terms
   always_comb begin
      nre = item.frame_start ? 9'sd0 : line_data;
      rc  = item.frame_start ? 8'sd0 : right_ff;
      p0  = item.frame_start ? 9'sd0 : pend0_ff;
      p1  = item.frame_start ? 9'sd0 : pend1_ff;
      sum = $signed({3'b000, item.pixel}) + 11'(nre) + 11'(rc);
      if (sum < 0) begin
         sat = 8'd0;
      end else if (sum > 11'sd255) begin
         sat = 8'd255;
      end else begin
         sat = sum[7:0];
      end
      dq  = sat > 8'd128;
      err = 9'($signed({2'b00, sat}) - (dq ? 10'sd255 : 10'sd0));
      spread  = !item.last_col && !item.last_row;
      t_right = spread ? scale_err(err, 4'd7) : 8'sd0;
      if (!spread) begin
         t_below = 8'sd0;
         t_bl    = 8'sd0;
         t_br    = 8'sd0;
      end else if (item.col_zero) begin
         t_below = scale_err(err, 4'd7);
         t_bl    = 8'sd0;
         t_br    = scale_err(err, 4'd2);
      end else begin
         t_below = scale_err(err, 4'd5);
         t_bl    = scale_err(err, 4'd3);
         t_br    = scale_err(err, 4'd1);
      end
      w1_sum  = 10'(p0) + 10'(t_bl);
      p0_next = 10'(p1) + 10'(t_below);
   end

   // output pixel by mode
   always_comb begin
      case (mode)
         MODE_THRESHOLD: pixel_q = (item.pixel > 8'd128) ? 8'd255 : 8'd0;
         MODE_BAYER:     pixel_q = ({2'b00, item.pixel[7:2]} >
                                    {2'b00, bayer_level(item.bayer_row, item.bayer_col)})
                                   ? 8'd1 : 8'd0;
         MODE_DIFFUSE:   pixel_q = dq ? 8'd255 : 8'd0;
         default:        pixel_q = item.pixel;
      endcase
   end

   // line store writes: below-left entry now, own entry at row end
   always_comb begin
      diff_fire  = fire && (mode == MODE_DIFFUSE);
      frame_end  = item.last_col && item.last_row;
      line_clear = fire && (item.frame_start || frame_end);
      w1_en      = diff_fire && !frame_end && !item.col_zero;
      w2_direct  = diff_fire && !frame_end && item.last_col && item.col_zero;
      q_set      = diff_fire && !frame_end && item.last_col && !item.col_zero;
      q_issue    = q_pend_ff && !w1_en && !w2_direct && !line_clear;
      ls_ctl.wr_en = w1_en || w2_direct || q_issue;
      ls_ctl.clear = line_clear;
      if (w1_en) begin
         ls_addr = col - COL_W'(1);
         ls_data = w1_sum[8:0];
      end else if (w2_direct) begin
         ls_addr = col;
         ls_data = p1;
      end else begin
         ls_addr = q_addr_ff;
         ls_data = q_data_ff;
      end
   end

   // deferred row-end write
   always_comb begin
      q_pend_in = q_pend_ff;
      q_addr_in = q_addr_ff;
      q_data_in = q_data_ff;
      if (q_set) begin
         q_pend_in = 1'b1;
         q_addr_in = col;
         q_data_in = p1;
      end else if (q_issue || line_clear) begin
         q_pend_in = 1'b0;
      end
   end

   // right-carry and pending-below errors
   always_comb begin
      right_in = right_ff;
      pend0_in = pend0_ff;
      pend1_in = pend1_ff;
      if (fire) begin
         if (frame_end) begin
            right_in = 8'sd0;
            pend0_in = 9'sd0;
            pend1_in = 9'sd0;
         end else if (diff_fire) begin
            right_in = item.last_col ? 8'sd0 : t_right;
            pend0_in = item.last_col ? 9'sd0 : p0_next[8:0];
            pend1_in = item.last_col ? 9'sd0 : 9'(t_br);
         end else if (item.frame_start) begin
            right_in = 8'sd0;
            pend0_in = 9'sd0;
            pend1_in = 9'sd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         right_ff  <= 8'sd0;
         pend0_ff  <= 9'sd0;
         pend1_ff  <= 9'sd0;
         q_pend_ff <= 1'b0;
      end else begin
         right_ff  <= right_in;
         pend0_ff  <= pend0_in;
         pend1_ff  <= pend1_in;
         q_pend_ff <= q_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      q_addr_ff <= q_addr_in;
      q_data_ff <= q_data_in;
   end

   // a clear leaves no deferred write behind
   a_clear_drops_deferred: assert property (@(posedge clock) disable iff (reset)
      ls_ctl.clear |=> !q_pend_ff)
      else $error("quant: deferred write survives a clear");

endmodule
